/* hw/rtl/relaxation_linear_solver_assert.svh */
// Assertion macros used by the checker file of the solver.
`ifndef RELAXATION_LINEAR_SOLVER_ASSERT_SVH
`define RELAXATION_LINEAR_SOLVER_ASSERT_SVH
// Same-cycle implication, checked at each rising clock edge outside reset.
`define SRL_ASSERT_IMPL(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("solver assertion failed");
// Next-cycle implication, checked at each rising clock edge outside reset.
`define SRL_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("solver assertion failed");
`endif

/* hw/rtl/srl_pkg.sv */
// ----------------------------------------------------------------------------
// srl_pkg
// Types, constants and helper functions shared by the relaxation solver.
// ----------------------------------------------------------------------------
package srl_pkg;

  localparam int MAX_UNKNOWNS = 16;
  localparam int IDX_W        = 4;
  localparam int N_W          = 5;
  localparam int CFG_W        = 31;
  localparam int DVD_W        = 51;

  localparam logic [1:0] FUNC_MATRIX = 2'd0;
  localparam logic [1:0] FUNC_RHS    = 2'd1;
  localparam logic [1:0] FUNC_GUESS  = 2'd2;
  localparam logic [1:0] FUNC_START  = 2'd3;

  localparam logic [1:0] CFG_SIZE     = 2'd0;
  localparam logic [1:0] CFG_MAX_ITER = 2'd1;
  localparam logic [1:0] CFG_TOL      = 2'd2;
  localparam logic [1:0] CFG_DAMP     = 2'd3;

  typedef struct packed {
    logic [1:0]        func;
    logic [3:0]        row;
    logic [3:0]        col;
    logic signed [31:0] value;
  } in_data_t;

  typedef struct packed {
    logic [3:0]         index;
    logic signed [31:0] solution;
    logic               last;
    logic               converged;
    logic [15:0]        sweeps;
    logic               zero_pivot;
  } out_data_t;

  typedef enum logic [3:0] {
    ST_IDLE, ST_CHECK, ST_DOT_RD, ST_DOT_MUL, ST_DOT_ACC, ST_RES, ST_SCALE,
    ST_DIV_GO, ST_DIV_WAIT, ST_ROW_END, ST_OUT_LOAD, ST_OUT_WAIT
  } state_t;

  // Clamp a wide signed value to the signed 32-bit range.
  function automatic logic [31:0] sat32(input logic signed [65:0] v);
    if (v > 66'sd2147483647) begin
      return 32'h7fff_ffff;
    end else if (v < -66'sd2147483648) begin
      return 32'h8000_0000;
    end else begin
      return v[31:0];
    end
  endfunction

endpackage

/* hw/rtl/srl_ram.sv */
// ----------------------------------------------------------------------------
// srl_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module srl_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 256,
  parameter int AW    = $clog2(DEPTH)
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

/* hw/rtl/srl_div.sv */
// ----------------------------------------------------------------------------
// srl_div
// Radix-2 restoring divider, one quotient bit per cycle, truncating toward zero.
// ----------------------------------------------------------------------------
module srl_div
  import srl_pkg::*;
(
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    start,
  input  logic signed [DVD_W-1:0] dividend,
  input  logic signed [31:0]      divisor,
  output logic                    done,
  output logic signed [DVD_W-1:0] quotient
);

  localparam int QW = DVD_W - 1;

  logic              busy_r;
  logic              done_r;
  logic [5:0]        cnt_r;
  logic [QW-1:0]     q_r;
  logic [31:0]       rem_r;
  logic [31:0]       dvs_r;
  logic              neg_r;
  logic [32:0]       rem_sh;
  logic              fits;
  logic [DVD_W-1:0]  dvd_abs;

  assign dvd_abs = dividend[DVD_W-1] ? DVD_W'(-dividend) : dividend;
  assign rem_sh  = {rem_r, q_r[QW-1]};
  assign fits    = rem_sh >= {1'b0, dvs_r};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= 6'(QW);
      end else if (busy_r) begin
        cnt_r <= cnt_r - 6'd1;
        if (cnt_r == 6'd1) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      q_r   <= dvd_abs[QW-1:0];
      rem_r <= '0;
      dvs_r <= divisor[31] ? 32'(-divisor) : divisor;
      neg_r <= dividend[DVD_W-1] ^ divisor[31];
    end else if (busy_r) begin
      if (fits) begin
        rem_r <= 32'(rem_sh - {1'b0, dvs_r});
        q_r   <= {q_r[QW-2:0], 1'b1};
      end else begin
        rem_r <= rem_sh[31:0];
        q_r   <= {q_r[QW-2:0], 1'b0};
      end
    end
  end

  assign done     = done_r;
  assign quotient = neg_r ? DVD_W'(-{1'b0, q_r}) : {1'b0, q_r};

endmodule

/* hw/rtl/relaxation_linear_solver.sv */
// A start transaction solves in sweeps: each matrix term takes the read, multiply and
// accumulate steps on the shared multiplier, and each row then waits on the 50-step
// divider, which a row with a zero diagonal skips. Results then leave one at a time,
// each loaded only after the consumer has taken the one before it.
// Throughput: one solve at a time; loads one per cycle while idle. Reset: synchronous
// active-low; the solution store is cleared to zero, matrix and rhs stores are kept.
// ----------------------------------------------------------------------------
// relaxation_linear_solver
// Damped Gauss-Seidel solver in Q16.16 with a shared multiply/accumulate path
// and an iterative divider under a small sequencer.
// ----------------------------------------------------------------------------
module relaxation_linear_solver
  import srl_pkg::*;
(
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_valid,
  output logic             in_stall,
  input  in_data_t         in_data,
  output logic             out_valid,
  input  logic             out_stall,
  output out_data_t        out_data,
  input  logic             cfg_we,
  input  logic [1:0]       cfg_addr,
  input  logic [CFG_W-1:0] cfg_wdata
);

  // Configuration registers.
  logic [4:0]  size_r;
  logic [15:0] max_iter_r;
  logic [30:0] tol_r;
  logic [17:0] damp_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      size_r     <= 5'd16;
      max_iter_r <= 16'd100;
      tol_r      <= 31'd66;
      damp_r     <= 18'd65536;
    end else if (cfg_we) begin
      unique case (cfg_addr)
        CFG_SIZE:     size_r     <= cfg_wdata[4:0];
        CFG_MAX_ITER: max_iter_r <= cfg_wdata[15:0];
        CFG_TOL:      tol_r      <= cfg_wdata[30:0];
        CFG_DAMP:     damp_r     <= cfg_wdata[17:0];
        default:      ;
      endcase
    end
  end

  // Sequencer state and datapath registers.
  state_t                    state_r, state_nxt;
  logic [N_W-1:0]            n_r, n_nxt;
  logic [IDX_W-1:0]          j_r, j_nxt;
  logic [IDX_W-1:0]          k_r, k_nxt;
  logic [15:0]               sweeps_r, sweeps_nxt;
  logic                      pend_r, pend_nxt;
  logic                      swp_pend_r, swp_pend_nxt;
  logic                      zp_r, zp_nxt;
  logic signed [63:0]        acc_r, acc_nxt;
  logic signed [63:0]        prod_r, prod_nxt;
  logic signed [31:0]        xk_r, xk_nxt;
  logic signed [31:0]        diag_r, diag_nxt;
  logic signed [31:0]        res_r, res_nxt;
  logic signed [DVD_W-1:0]   dvd_r, dvd_nxt;
  logic                      out_valid_r, out_valid_nxt;
  out_data_t                 out_data_r, out_data_nxt;

  // Solution store: zero after reset, one shared read select.
  logic signed [31:0]        sol_r [MAX_UNKNOWNS];
  logic [IDX_W-1:0]          sol_ra;
  logic signed [31:0]        sol_rd;
  logic                      sol_we;
  logic [IDX_W-1:0]          sol_wa;
  logic signed [31:0]        sol_wd;

  // Right-hand side store, read at the current row only.
  logic signed [31:0]        rhs_r [MAX_UNKNOWNS];

  logic                      in_acc;
  logic                      ram_we;
  logic [2*IDX_W-1:0]        ram_raddr;
  logic [31:0]               ram_rdata;
  logic                      div_start;
  logic                      div_done;
  logic signed [DVD_W-1:0]   div_quot;
  logic [N_W-1:0]            n_cfg;
  logic [IDX_W-1:0]          n_last;
  logic [31:0]               res_mag;

  assign in_acc   = in_valid && !in_stall;
  assign in_stall = (state_r != ST_IDLE);
  assign ram_we   = in_acc && (in_data.func == FUNC_MATRIX);
  assign sol_rd   = sol_r[sol_ra];
  assign n_last   = IDX_W'(n_r - N_W'(1));
  assign res_mag  = res_r[31] ? 32'(-res_r) : res_r;

  always_comb begin
    if (size_r == 5'd0) begin
      n_cfg = N_W'(1);
    end else if (size_r > N_W'(MAX_UNKNOWNS)) begin
      n_cfg = N_W'(MAX_UNKNOWNS);
    end else begin
      n_cfg = size_r;
    end
  end

  srl_ram #(.WIDTH(32), .DEPTH(MAX_UNKNOWNS * MAX_UNKNOWNS)) u_matrix (
    .clk   (clk),
    .we    (ram_we),
    .waddr ({in_data.row, in_data.col}),
    .wdata (in_data.value),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  srl_div u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start),
    .dividend (dvd_r),
    .divisor  (diag_r),
    .done     (div_done),
    .quotient (div_quot)
  );

  always_comb begin
    state_nxt     = state_r;
    n_nxt         = n_r;
    j_nxt         = j_r;
    k_nxt         = k_r;
    sweeps_nxt    = sweeps_r;
    pend_nxt      = pend_r;
    swp_pend_nxt  = swp_pend_r;
    zp_nxt        = zp_r;
    acc_nxt       = acc_r;
    prod_nxt      = prod_r;
    xk_nxt        = xk_r;
    diag_nxt      = diag_r;
    res_nxt       = res_r;
    dvd_nxt       = dvd_r;
    out_valid_nxt = out_valid_r;
    out_data_nxt  = out_data_r;
    ram_raddr     = {j_r, k_r};
    sol_ra        = k_r;
    sol_we        = 1'b0;
    sol_wa        = in_data.row;
    sol_wd        = in_data.value;
    div_start     = 1'b0;

    unique case (state_r)
      ST_IDLE: begin
        if (in_acc && in_data.func == FUNC_GUESS) begin
          sol_we = 1'b1;
        end
        if (in_acc && in_data.func == FUNC_START) begin
          n_nxt      = n_cfg;
          sweeps_nxt = '0;
          pend_nxt   = 1'b1;
          zp_nxt     = 1'b0;
          state_nxt  = ST_CHECK;
        end
      end
      ST_CHECK: begin
        j_nxt = '0;
        k_nxt = '0;
        if (sweeps_r < max_iter_r && pend_r) begin
          acc_nxt      = '0;
          swp_pend_nxt = 1'b0;
          state_nxt    = ST_DOT_RD;
        end else begin
          state_nxt = ST_OUT_LOAD;
        end
      end
      ST_DOT_RD: begin
        xk_nxt    = sol_rd;
        state_nxt = ST_DOT_MUL;
      end
      ST_DOT_MUL: begin
        prod_nxt = $signed(ram_rdata) * xk_r;
        if (k_r == j_r) begin
          diag_nxt = $signed(ram_rdata);
        end
        state_nxt = ST_DOT_ACC;
      end
      ST_DOT_ACC: begin
        // Arithmetic shift gives the floor of the Q32.32 product.
        acc_nxt = acc_r + (prod_r >>> 16);
        if (k_r == n_last) begin
          state_nxt = ST_RES;
        end else begin
          k_nxt     = k_r + IDX_W'(1);
          state_nxt = ST_DOT_RD;
        end
      end
      ST_RES: begin
        res_nxt   = $signed(sat32(66'(rhs_r[j_r]) - 66'(acc_r)));
        state_nxt = ST_SCALE;
      end
      ST_SCALE: begin
        if (res_mag > {1'b0, tol_r}) begin
          swp_pend_nxt = 1'b1;
        end
        if (diag_r == 32'sd0) begin
          zp_nxt    = 1'b1;
          state_nxt = ST_ROW_END;
        end else begin
          dvd_nxt   = $signed({1'b0, damp_r}) * res_r;
          state_nxt = ST_DIV_GO;
        end
      end
      ST_DIV_GO: begin
        div_start = 1'b1;
        state_nxt = ST_DIV_WAIT;
      end
      ST_DIV_WAIT: begin
        sol_ra = j_r;
        if (div_done) begin
          sol_we    = 1'b1;
          sol_wa    = j_r;
          sol_wd    = $signed(sat32(66'(sol_rd) + 66'(div_quot)));
          state_nxt = ST_ROW_END;
        end
      end
      ST_ROW_END: begin
        k_nxt   = '0;
        acc_nxt = '0;
        if (j_r == n_last) begin
          sweeps_nxt = sweeps_r + 16'd1;
          pend_nxt   = swp_pend_r;
          state_nxt  = ST_CHECK;
        end else begin
          j_nxt     = j_r + IDX_W'(1);
          state_nxt = ST_DOT_RD;
        end
      end
      ST_OUT_LOAD: begin
        sol_ra                  = j_r;
        out_data_nxt.index      = j_r;
        out_data_nxt.solution   = sol_rd;
        out_data_nxt.last       = (j_r == n_last);
        out_data_nxt.converged  = !pend_r;
        out_data_nxt.sweeps     = sweeps_r;
        out_data_nxt.zero_pivot = zp_r;
        out_valid_nxt           = 1'b1;
        state_nxt               = ST_OUT_WAIT;
      end
      ST_OUT_WAIT: begin
        if (out_valid_r && !out_stall) begin
          out_valid_nxt = 1'b0;
          if (out_data_r.last) begin
            state_nxt = ST_IDLE;
          end else begin
            j_nxt     = j_r + IDX_W'(1);
            state_nxt = ST_OUT_LOAD;
          end
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    n_r        <= n_nxt;
    j_r        <= j_nxt;
    k_r        <= k_nxt;
    sweeps_r   <= sweeps_nxt;
    pend_r     <= pend_nxt;
    swp_pend_r <= swp_pend_nxt;
    zp_r       <= zp_nxt;
    acc_r      <= acc_nxt;
    prod_r     <= prod_nxt;
    xk_r       <= xk_nxt;
    diag_r     <= diag_nxt;
    res_r      <= res_nxt;
    dvd_r      <= dvd_nxt;
    out_data_r <= out_data_nxt;
  end

  // The solution store resets to zero, as a stored guess of zero.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int e = 0; e < MAX_UNKNOWNS; e++) begin
        sol_r[e] <= '0;
      end
    end else if (sol_we) begin
      sol_r[sol_wa] <= sol_wd;
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc && in_data.func == FUNC_RHS) begin
      rhs_r[in_data.row] <= in_data.value;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule

/* hw/rtl/srl_checker.sv */
// ----------------------------------------------------------------------------
// srl_checker
// Port-level checks of the solver's transaction sequencing.
// ----------------------------------------------------------------------------
`include "relaxation_linear_solver_assert.svh"

module srl_checker
  import srl_pkg::*;
(
  input logic      clk,
  input logic      rst_n,
  input logic      in_valid,
  input logic      in_stall,
  input in_data_t  in_data,
  input logic      out_valid,
  input logic      out_stall,
  input out_data_t out_data
);

  `SRL_ASSERT_NEXT(a_out_hold, out_valid && out_stall, out_valid && $stable(out_data))
  `SRL_ASSERT_IMPL(a_busy_emit, out_valid, in_stall)
  `SRL_ASSERT_NEXT(a_last_idle, out_valid && !out_stall && out_data.last, !out_valid)
  `SRL_ASSERT_NEXT(a_start_busy, in_valid && !in_stall && in_data.func == FUNC_START, in_stall)

endmodule

bind relaxation_linear_solver srl_checker u_srl_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_valid  (in_valid),
  .in_stall  (in_stall),
  .in_data   (in_data),
  .out_valid (out_valid),
  .out_stall (out_stall),
  .out_data  (out_data)
);
